// ===== design/gpce_pkg.sv =====
`timescale 1ns / 1ps
package gpce_pkg;

  // Register indexes of the configuration port
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_MEAN  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SIGMA = 1'b1;

  // Field widths
  localparam int ZW   = 21;  // |z| in Q16.16, clamped to 16.0
  localparam int PHIW = 31;  // standard density in Q32
  localparam int TW   = 32;  // t in Q31
  localparam int PW   = 32;  // polynomial value in Q30, never negative
  localparam int SGW  = 31;  // sigma
  localparam int NW   = 8;   // integer part of z^2/2 over ln2

  // Fixed-point constants
  localparam logic [32:0]   ONE_Q32      = 33'h1_0000_0000;
  localparam logic [31:0]   LN2_Q32      = 32'd2977044472;
  localparam logic [30:0]   INVSQ2PI_Q32 = 31'd1713444047;
  localparam logic [29:0]   B0_Q32       = 30'd994894385;
  localparam logic [ZW-1:0] Z_MAX        = 21'h10_0000;
  localparam logic [16:0]   CUM_ONE      = 17'h1_0000;

  // Series and polynomial orders
  localparam int SERIES_TERMS = 14;
  localparam int POLY_ORDER   = 5;

  localparam logic signed [33:0] POLY_COEF [POLY_ORDER] = '{
    34'sd342933307,
    -34'sd382857446,
    34'sd1912847369,
    -34'sd1955558716,
    34'sd1428371292
  };

  // Stage counts of the pipelined units
  localparam int ZDIV_LAT = ZW;
  localparam int NDIV_LAT = 3;  // reciprocal estimate, remainder, correction
  localparam int EXP_LAT  = 1 + NDIV_LAT + 3 * SERIES_TERMS + 2;
  localparam int TDIV_LAT = TW;
  localparam int POLY_LAT = 2 * POLY_ORDER;
  localparam int DDIV_LAT = PHIW;

endpackage

// ===== design/gaussian_pdf_cdf_eval_top.sv =====
`timescale 1ns / 1ps
// Gaussian density and normal CDF evaluator.
// Input stream: one beat per abscissa, signed Q16.16 in in_tdata.
// Output stream: one beat per input beat, in order: density (unsigned Q16.16)
// in out_tdata[31:0], cumulative probability (65536 = 1.0) in out_tdata[48:32].
// Configuration: write mean (index 0) and sigma (index 1) through cfg_we /
// cfg_addr / cfg_wdata while no beat is in flight; a zero sigma counts as one LSB.
// Throughput: one beat per cycle while the pipeline does not hold. The path
// is a fixed pipeline: a 21-stage divider for z, a 48-stage exponential, a
// 32-stage divider for t and a 10-stage polynomial after it, both beside the
// exponential, then a 31-stage divider for density. The z divider, exponential
// and density divider set the latency; every stage takes a new beat each cycle.
// Reset (synchronous, active low) empties the pipeline, drops any held result
// and returns mean to 0 and sigma to 1.0.
// Stall: while the output holds a beat that is not taken, the pipeline keeps
// moving until a finished beat reaches its last stage; only then does the
// whole pipeline hold and in_tready drop. Nothing is lost or repeated.
module gaussian_pdf_cdf_eval_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] abscissa
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata,  // [31:0] density, [48:32] cumulative
  input  logic                          cfg_we,
  input  logic [gpce_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [31:0]                   cfg_wdata
);
  import gpce_pkg::*;

  // Stage at which each value sits in its register (accept edge = stage 1)
  localparam int C_Z   = 2 + ZDIV_LAT + 1;
  localparam int C_PHI = C_Z + EXP_LAT;
  localparam int C_P   = C_Z + 1 + TDIV_LAT + POLY_LAT;
  localparam int C_D   = C_PHI + DDIV_LAT;

  // Configuration registers
  logic [31:0]     mean_r;
  logic [SGW-1:0]  sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      sigma_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MEAN:  mean_r  <= cfg_wdata;
        REG_SIGMA: sigma_r <= cfg_wdata[SGW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold only when a finished beat meets a stalled output
  logic en;
  logic vld_last;
  logic out_valid_r;
  logic out_valid_nxt;

  assign en        = !(vld_last && out_valid_r && !out_tready);
  assign in_tready = en;

  gpce_delay #(.W(1), .DEPTH(C_D)) u_vld (
    .clk (clk), .rst_n (rst_n), .en (en), .d (in_tvalid), .q (vld_last)
  );

  // Stage 1: deviation from mean, magnitude and sign
  logic [32:0]    dev;
  logic           neg1_r;
  logic [32:0]    mag1_r;
  logic [SGW-1:0] sg1_r;

  assign dev = {in_tdata[31], in_tdata} - {mean_r[31], mean_r};

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= dev[32];
      mag1_r <= dev[32] ? (33'd0 - dev) : dev;
      sg1_r  <= (sigma_r == '0) ? SGW'(1) : sigma_r;
    end
  end

  // Stage 2: catch quotients beyond 21 bits, which clamp anyway
  logic [48:0]    dvd2_r;
  logic [SGW-1:0] sg2_r;
  logic           ovf2_r;
  logic           ovf;

  assign ovf = ({3'd0, mag1_r[32:5]} >= sg1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ovf2_r <= ovf;
      dvd2_r <= ovf ? '0 : {mag1_r, 16'd0};
      sg2_r  <= sg1_r;
    end
  end

  // |z| = (|d| << 16) / sigma
  logic [ZW-1:0] zq;
  logic          ovf_d;
  logic [ZW-1:0] zc_r;

  gpce_div #(.DW(49), .VW(SGW), .QW(ZDIV_LAT)) u_zdiv (
    .clk (clk), .en (en), .dividend (dvd2_r), .divisor (sg2_r),
    .quotient (zq), .remainder ()
  );

  gpce_delay #(.W(1), .DEPTH(ZDIV_LAT)) u_ovf (
    .clk (clk), .rst_n (rst_n), .en (en), .d (ovf2_r), .q (ovf_d)
  );

  always_ff @(posedge clk) begin
    if (en) zc_r <= (ovf_d || (zq > Z_MAX)) ? Z_MAX : zq;
  end

  // Density branch
  logic [PHIW-1:0] phi;

  gpce_exp u_exp (
    .clk (clk), .en (en), .z (zc_r), .phi (phi)
  );

  // CDF branch: t = 2^63 / (2^32 + B0*|z|/2^16)
  logic [50:0] bz;
  logic [34:0] den_r;
  logic [TW-1:0] t;
  logic [PW-1:0] pv;
  logic [PW-1:0] pv_d;

  assign bz = B0_Q32 * zc_r;

  always_ff @(posedge clk) begin
    if (en) den_r <= {2'd0, ONE_Q32} + bz[50:16];
  end

  gpce_div #(.DW(64), .VW(35), .QW(TDIV_LAT)) u_tdiv (
    .clk (clk), .en (en), .dividend (64'h8000_0000_0000_0000), .divisor (den_r),
    .quotient (t), .remainder ()
  );

  gpce_poly u_poly (
    .clk (clk), .en (en), .t (t), .p (pv)
  );

  gpce_delay #(.W(PW), .DEPTH(C_PHI - C_P)) u_pdly (
    .clk (clk), .rst_n (rst_n), .en (en), .d (pv), .q (pv_d)
  );

  // Tail = phi * P, rounded into Q16, mirrored for negative deviation
  logic        neg_d;
  logic [62:0] tp_r;
  logic [63:0] tr;
  logic [17:0] tail;
  logic [16:0] tail_c;
  logic [16:0] cum_r;
  logic [16:0] cum_d;

  gpce_delay #(.W(1), .DEPTH(C_PHI)) u_neg (
    .clk (clk), .rst_n (rst_n), .en (en), .d (neg1_r), .q (neg_d)
  );

  assign tr     = {1'b0, tp_r} + 64'h0000_2000_0000_0000;
  assign tail   = tr[63:46];
  assign tail_c = (tail > {1'b0, CUM_ONE}) ? CUM_ONE : tail[16:0];

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r  <= phi * pv_d;
      cum_r <= neg_d ? tail_c : (CUM_ONE - tail_c);
    end
  end

  gpce_delay #(.W(17), .DEPTH(C_D - C_PHI - 2)) u_cdly (
    .clk (clk), .rst_n (rst_n), .en (en), .d (cum_r), .q (cum_d)
  );

  // density = phi / sigma
  logic [SGW-1:0] sg_d;
  logic [PHIW-1:0] dq;

  gpce_delay #(.W(SGW), .DEPTH(C_PHI - 2)) u_sdly (
    .clk (clk), .rst_n (rst_n), .en (en), .d (sg2_r), .q (sg_d)
  );

  gpce_div #(.DW(32), .VW(SGW), .QW(DDIV_LAT)) u_ddiv (
    .clk (clk), .en (en), .dividend ({1'b0, phi}), .divisor (sg_d),
    .quotient (dq), .remainder ()
  );

  // Output register
  logic [31:0] dens_r;
  logic [16:0] cum_out_r;

  assign out_valid_nxt = (en && vld_last) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_last) begin
      dens_r    <= {1'b0, dq};
      cum_out_r <= cum_d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, cum_out_r, dens_r};

endmodule

// ===== design/gpce_delay.sv =====
`timescale 1ns / 1ps
module gpce_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) line_r[i] <= '0;
    end else if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) line_r[i] <= line_r[i-1];
    end
  end

  assign q = line_r[DEPTH-1];

endmodule

// ===== design/gpce_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage. The quotient must fit in QW bits.
module gpce_div #(
  parameter int DW = 32,
  parameter int VW = 31,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  logic [VW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [VW-1:0] dvs_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic [VW-1:0] rem_in;
    logic [VW-1:0] dvs_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [VW:0]   rs;
    logic [VW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = VW'(dividend[DW-1:QW]);
      assign low_in = dividend[QW-1:0];
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign quo_in = quo_r[s-1];
      assign dvs_in = dvs_r[s-1];
    end

    assign rs   = {rem_in, low_in[QW-1]};
    assign diff = rs - {1'b0, dvs_in};
    assign ge   = (rs >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[VW-1:0] : rs[VW-1:0];
        low_r[s] <= {low_in[QW-2:0], 1'b0};
        quo_r[s] <= {quo_in[QW-2:0], ge};
        dvs_r[s] <= dvs_in;
      end
    end
  end

  assign quotient  = quo_r[QW-1];
  assign remainder = rem_r[QW-1];

endmodule

// ===== design/gpce_exp.sv =====
`timescale 1ns / 1ps
// Standard density phi(z) = exp(-z^2/2)/sqrt(2*pi) in Q32.
module gpce_exp (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gpce_pkg::ZW-1:0]   z,
  output logic [gpce_pkg::PHIW-1:0] phi
);
  import gpce_pkg::*;

  logic [2*ZW-1:0] zz;
  logic [39:0]     q_r;
  logic [NW-1:0]   n0_r;
  logic [31:0]     r0_r;

  assign zz = z * z;

  always_ff @(posedge clk) begin
    if (en) q_r <= zz[40:1];
  end

  // split z^2/2 into n*ln2 + r: reciprocal estimate, then one correction
  localparam logic [16:0] LN2_RECIP = 17'((64'd1 << 48) / 64'(LN2_Q32));

  logic [39:0]   nm;
  logic [NW-1:0] ns1_r;
  logic [39:0]   qs1_r;
  logic [39:0]   nl;
  logic [39:0]   rs;
  logic [NW-1:0] ns2_r;
  logic [32:0]   rs2_r;

  assign nm = q_r[39:16] * LN2_RECIP;
  assign nl = ns1_r * LN2_Q32;
  assign rs = qs1_r - nl;

  always_ff @(posedge clk) begin
    if (en) begin
      ns1_r <= nm[39:32];
      qs1_r <= q_r;
      ns2_r <= ns1_r;
      rs2_r <= rs[32:0];
      if (rs2_r >= {1'b0, LN2_Q32}) begin
        n0_r <= ns2_r + NW'(1);
        r0_r <= 32'(rs2_r - {1'b0, LN2_Q32});
      end else begin
        n0_r <= ns2_r;
        r0_r <= rs2_r[31:0];
      end
    end
  end

  logic [63:0]   pa_r  [SERIES_TERMS];
  logic [31:0]   ra_r  [SERIES_TERMS];
  logic [NW-1:0] na_r  [SERIES_TERMS];
  logic [31:0]   pb_r  [SERIES_TERMS];
  logic [63:0]   mb_r  [SERIES_TERMS];
  logic [31:0]   rb_r  [SERIES_TERMS];
  logic [NW-1:0] nb_r  [SERIES_TERMS];
  logic [32:0]   res_r [SERIES_TERMS];
  logic [31:0]   rc_r  [SERIES_TERMS];
  logic [NW-1:0] nc_r  [SERIES_TERMS];

  // Horner series for e^-r, term k = SERIES_TERMS down to 1, three stages each
  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    localparam int unsigned KV = SERIES_TERMS - j;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / KV);

    logic [32:0]   res_in;
    logic [31:0]   r_in;
    logic [NW-1:0] n_in;
    logic [64:0]   prod;
    logic [63:0]   pm;
    logic [32:0]   res_nxt;

    if (j == 0) begin : g_first
      assign res_in = ONE_Q32;
      assign r_in   = r0_r;
      assign n_in   = n0_r;
    end else begin : g_next
      assign res_in = res_r[j-1];
      assign r_in   = rc_r[j-1];
      assign n_in   = nc_r[j-1];
    end

    assign prod = r_in * res_in;

    if (KV > 1) begin : g_div
      logic [31:0] q0;
      logic [35:0] rem0;
      logic [31:0] qk;

      assign pm   = pa_r[j][63:32] * RECIP;
      assign q0   = mb_r[j][63:32];
      assign rem0 = {4'd0, pb_r[j]} - (36'(q0) * 36'(KV));
      assign qk   = (rem0 >= 36'(KV)) ? q0 + 32'd1 : q0;
      assign res_nxt = ONE_Q32 - {1'b0, qk};
    end else begin : g_unit
      assign pm      = '0;
      assign res_nxt = ONE_Q32 - {1'b0, pb_r[j]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[j]  <= prod[63:0];
        ra_r[j]  <= r_in;
        na_r[j]  <= n_in;
        pb_r[j]  <= pa_r[j][63:32];
        mb_r[j]  <= pm;
        rb_r[j]  <= ra_r[j];
        nb_r[j]  <= na_r[j];
        res_r[j] <= res_nxt;
        rc_r[j]  <= rb_r[j];
        nc_r[j]  <= nb_r[j];
      end
    end
  end

  logic [32:0] e_r;
  logic [32:0] e_nxt;
  logic [63:0] pprod;
  logic [PHIW-1:0] phi_r;

  // scale by 2^-n
  assign e_nxt = (nc_r[SERIES_TERMS-1] >= NW'(64)) ? '0
               : (res_r[SERIES_TERMS-1] >> nc_r[SERIES_TERMS-1][5:0]);
  assign pprod = e_r * INVSQ2PI_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      e_r   <= e_nxt;
      phi_r <= pprod[62:32];
    end
  end

  assign phi = phi_r;

endmodule

// ===== design/gpce_poly.sv =====
`timescale 1ns / 1ps
// t * P(t) by Horner, Q30 coefficients, products truncated toward zero.
module gpce_poly (
  input  logic                    clk,
  input  logic                    en,
  input  logic [gpce_pkg::TW-1:0] t,
  output logic [gpce_pkg::PW-1:0] p
);
  import gpce_pkg::*;

  logic signed [66:0] pr_r  [POLY_ORDER];
  logic [TW-1:0]      ta_r  [POLY_ORDER];
  logic signed [33:0] acc_r [POLY_ORDER];
  logic [TW-1:0]      tb_r  [POLY_ORDER];

  for (genvar i = 0; i < POLY_ORDER; i++) begin : g_step
    logic signed [33:0] acc_in;
    logic [TW-1:0]      t_in;
    logic signed [66:0] prod;
    logic signed [66:0] shv;
    logic               adj;
    logic [33:0]        coef;
    logic [33:0]        sum;
    logic [33:0]        acc_nxt;

    if (i == 0) begin : g_first
      assign acc_in = POLY_COEF[POLY_ORDER-1];
      assign t_in   = t;
    end else begin : g_next
      assign acc_in = acc_r[i-1];
      assign t_in   = tb_r[i-1];
    end

    if (i < POLY_ORDER - 1) begin : g_add
      assign coef = POLY_COEF[POLY_ORDER-2-i];
    end else begin : g_last
      assign coef = '0;
    end

    assign prod = acc_in * $signed({1'b0, t_in});
    assign shv  = pr_r[i] >>> 31;
    assign adj  = pr_r[i][66] && (pr_r[i][30:0] != '0);
    assign sum  = shv[33:0] + {33'd0, adj} + coef;

    if (i == POLY_ORDER - 1) begin : g_clamp
      // a negative tail factor reads as zero
      assign acc_nxt = sum[33] ? '0 : sum;
    end else begin : g_pass
      assign acc_nxt = sum;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pr_r[i]  <= prod;
        ta_r[i]  <= t_in;
        acc_r[i] <= $signed(acc_nxt);
        tb_r[i]  <= ta_r[i];
      end
    end
  end

  assign p = acc_r[POLY_ORDER-1][PW-1:0];

endmodule

// ===== design/gpce_check.sv =====
`timescale 1ns / 1ps
module gpce_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // Reset drops any held result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat survives reset");

  // Cumulative never exceeds 1.0
  a_cum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[48:32] <= 17'h1_0000))
    else $error("cumulative above one");

  // Pad bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[55:49] == 7'd0))
    else $error("pad bits set");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

endmodule

bind gaussian_pdf_cdf_eval_top gpce_check u_check (.*);

// ===== tb/sv/tb_gaussian_pdf_cdf_eval_top.sv =====
`timescale 1ns / 1ps
module tb_gaussian_pdf_cdf_eval_top;
  import gpce_pkg::*;

  localparam int LATENCY = 104;
  localparam int N_RANDOM = 750;

  // Fixed-point constants of the evaluator, Q32 except K_ZMAX in Q16.16
  localparam logic [63:0] K_ONE      = 64'h1_0000_0000;
  localparam logic [63:0] K_LN2      = 64'd2977044472;
  localparam logic [63:0] K_INVSQ2PI = 64'd1713444047;
  localparam logic [63:0] K_B0       = 64'd994894385;
  localparam logic [63:0] K_ZMAX     = 64'd16 << 16;

  typedef struct packed {
    logic [31:0] density;
    logic [16:0] cumulative;
  } gauss_res_t;

  typedef struct {
    logic [31:0] abscissa;
    bit          known;      // expected result typed in below
    gauss_res_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_MEAN;
  logic [31:0] cfg_wdata = '0;

  // Local copy of the configuration
  logic signed [31:0] mean_q;
  logic [30:0]        sigma_q;

  gauss_res_t pending_q[$];
  int  n_fail = 0;
  bit  out_idle_off = 1'b0;

  gaussian_pdf_cdf_eval_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // Evaluate density and cumulative for one abscissa with the current setup.
  function automatic gauss_res_t gauss_eval(logic [31:0] x);
    logic signed [33:0] diff;
    logic [63:0] mag, sg, z, q, n, r, e, phi, dens, den, t, tail, prod;
    logic signed [63:0] acc;
    gauss_res_t o;
    diff = $signed({{2{x[31]}}, x}) - $signed({{2{mean_q[31]}}, mean_q});
    mag  = diff[33] ? 64'(-diff) : 64'(diff);
    sg   = (sigma_q == 0) ? 64'd1 : 64'(sigma_q);
    z    = (mag << 16) / sg;
    if (z > K_ZMAX) z = K_ZMAX;
    q = (z * z) >> 1;
    n = q / K_LN2;
    r = q - n * K_LN2;
    // Horner series for e^-r, fourteen terms
    e = K_ONE;
    for (int k = 14; k >= 1; k--) begin
      prod = r * e;          // fits: r < 2^32, e <= 2^32
      e = K_ONE - (prod >> 32) / k;
    end
    e = (n >= 64) ? 64'd0 : (e >> n);
    phi  = (e * K_INVSQ2PI) >> 32;
    dens = phi / sg;
    if (dens > 64'hFFFF_FFFF) dens = 64'hFFFF_FFFF;
    den = K_ONE + ((K_B0 * z) >> 16);
    t   = (64'd1 << 63) / den;
    acc = 64'sd1428371292;
    acc = (acc * $signed(t)) / (64'sd1 << 31) - 64'sd1955558716;
    acc = (acc * $signed(t)) / (64'sd1 << 31) + 64'sd1912847369;
    acc = (acc * $signed(t)) / (64'sd1 << 31) - 64'sd382857446;
    acc = (acc * $signed(t)) / (64'sd1 << 31) + 64'sd342933307;
    acc = (acc * $signed(t)) / (64'sd1 << 31);
    if (acc < 0) acc = 0;
    tail = (phi * 64'(acc) + (64'd1 << 45)) >> 46;
    if (tail > 64'd65536) tail = 64'd65536;
    o.density    = dens[31:0];
    o.cumulative = diff[33] ? tail[16:0] : 17'(64'd65536 - tail);
    return o;
  endfunction

  // Hold the channel low for a random burst now and then.
  task automatic in_gap();
    if (!out_idle_off && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_beat(logic [31:0] x, bit known, gauss_res_t res);
    in_gap();
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    pending_q.push_back(known ? res : gauss_eval(x));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MEAN) mean_q = val;
    else sigma_q = val[30:0];
  endtask

  // Random receiver stalls, dropped in the last part of the run
  always @(posedge clk) begin : out_stall
    int hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold = hold - 1;
      out_tready <= (hold == 0);
    end else if (!out_idle_off && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(1, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each taken result beat with the oldest expectation
  always @(posedge clk) begin : check_out
    gauss_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_tdata);
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[31:0] !== want.density) begin
          $display("%0t: density expected %h actual %h", $time, want.density,
                   out_tdata[31:0]);
          n_fail++;
        end
        if (out_tdata[48:32] !== want.cumulative) begin
          $display("%0t: cumulative expected %h actual %h", $time, want.cumulative,
                   out_tdata[48:32]);
          n_fail++;
        end
      end
    end
  end

  stim_row_t rows[$];

  function automatic stim_row_t row(logic [31:0] x, bit known = 0,
                                    logic [31:0] dens = 0, logic [16:0] cum = 0);
    stim_row_t s;
    s.abscissa = x;
    s.known = known;
    s.res.density = dens;
    s.res.cumulative = cum;
    return s;
  endfunction

  task automatic random_phase(int count);
    logic [31:0] x;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: x = $urandom;                                          // any value
        1: x = mean_q + $signed(32'($urandom_range(0, 1 << 20)) - (1 << 19));
        2: x = mean_q + ($urandom_range(0, 1) ? 1 : -1) *
               int'(sigma_q) * $urandom_range(0, 8);             // near whole z
        default: x = {{12{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 20'($urandom)};
      endcase
      send_beat(x, 0, '0);
    end
  endtask

  initial begin
    mean_q  = 0;
    sigma_q = 31'd65536;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset setup first; far tails have exact results
    rows.push_back(row(32'h0000_0000));
    rows.push_back(row(32'h7FFF_FFFF, 1, 32'd0, 17'd65536));
    rows.push_back(row(32'h8000_0000, 1, 32'd0, 17'd0));
    rows.push_back(row(32'h0010_0000));
    rows.push_back(row(32'hFFF0_0000));
    rows.push_back(row(32'h0001_0000));
    rows.push_back(row(32'hFFFF_0000));
    rows.push_back(row(32'h0000_0001));
    rows.push_back(row(32'hFFFF_FFFF));
    rows.push_back(row(32'h0011_0000, 1, 32'd0, 17'd65536));
    rows.push_back(row(32'h5555_AAAA));
    rows.push_back(row(32'hAAAA_5555));
    foreach (rows[i]) send_beat(rows[i].abscissa, rows[i].known, rows[i].res);
    drain();

    // Extreme setup: most negative mean, zero sigma (one LSB)
    write_reg(REG_MEAN, 32'h8000_0000);
    write_reg(REG_SIGMA, 32'h0);
    send_beat(32'h8000_0000, 0, '0);
    send_beat(32'h8000_0001, 0, '0);
    send_beat(32'h7FFF_FFFF, 1, '{32'd0, 17'd65536});
    send_beat(32'hFFFF_FFFF, 0, '0);
    drain();

    // Largest sigma, largest mean
    write_reg(REG_MEAN, 32'h7FFF_FFFF);
    write_reg(REG_SIGMA, 32'h7FFF_FFFF);
    send_beat(32'h8000_0000, 0, '0);
    send_beat(32'h7FFF_FFFF, 0, '0);
    send_beat(32'h0000_0000, 0, '0);
    send_beat(32'hFFFF_FFFF, 0, '0);
    drain();

    // Random phases under several setups; each drain is a full sender pause
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MEAN, (ph == 0) ? 32'h0 : $urandom_range(0, 1) ?
                $urandom : 32'($urandom_range(0, 1 << 22)) - (1 << 21));
      write_reg(REG_SIGMA, (ph == 0) ? 32'd65536 : 32'($urandom_range(1, 1 << 20)) <<
                $urandom_range(0, 10));
      if (ph == 4) out_idle_off = 1'b1;
      random_phase(N_RANDOM / 5);
      drain();
    end

    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gpce_pkg.sv
design/gpce_delay.sv
design/gpce_div.sv
design/gpce_exp.sv
design/gpce_poly.sv
design/gaussian_pdf_cdf_eval_top.sv
design/gpce_check.sv
tb/sv/tb_gaussian_pdf_cdf_eval_top.sv
